[sv/obstacle_gap_fit_tracker_core_assert.svh]
// assertion macros for the gap fit tracker
`ifndef OBSTACLE_GAP_FIT_TRACKER_CORE_ASSERT_SVH
`define OBSTACLE_GAP_FIT_TRACKER_CORE_ASSERT_SVH
`ifndef SYNTH
`define OGFT_ASSERT_IMPL(lbl, a, c) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (a) |-> (c)) else $error("implication check failed");
`define OGFT_ASSERT_NEXT(lbl, a, c) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (a) |=> (c)) else $error("next-cycle check failed");
`else
`define OGFT_ASSERT_IMPL(lbl, a, c)
`define OGFT_ASSERT_NEXT(lbl, a, c)
`endif
`endif

[sv/ogft_pkg.sv]
package ogft_pkg;
	localparam int POS_W = 11;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_FIT    = 1'b1;

	typedef enum logic [9:0] {
		ST_CLR   = 10'b0000000001,
		ST_IDLE  = 10'b0000000010,
		ST_ICHK  = 10'b0000000100,
		ST_BELOW = 10'b0000001000,
		ST_ABOVE = 10'b0000010000,
		ST_TWR   = 10'b0000100000,
		ST_TMX   = 10'b0001000000,
		ST_QA    = 10'b0010000000,
		ST_QB    = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;
endpackage

[sv/obstacle_gap_fit_tracker_core.sv]
// insert: the map words are scanned for both neighbors (32 positions per word, one word a
//   cycle), then the gap tree (depth ~11) is updated from both new leaves up to the root
// fit query: map scan down, tree range max, then the done strobe; position 0 answers in the next cycle
// throughput: one command at a time, busy stays high until the command finishes
// reset: a clearing pass sweeps both memories, busy is high meanwhile
// the result receiver cannot stall: fits is valid only in the cycle done is high
module obstacle_gap_fit_tracker_core #(
	parameter int MAX_POS = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       command,
	input  logic [ogft_pkg::POS_W-1:0] position,
	input  logic [ogft_pkg::POS_W-1:0] block_size,
	output logic                       done,
	output logic                       fits
);
	import ogft_pkg::*;

	// line 0 .. MAX_POS+1, both ends are fixed marks
	localparam int SLOTS = MAX_POS + 2;
	localparam int TSZ   = 2 * SLOTS;
	localparam int TW    = $clog2(TSZ);
	localparam int GW    = $clog2(MAX_POS + 1);
	// obstacle map packed 32 positions per word
	localparam int MW    = (SLOTS + 31) / 32;
	localparam int MAW   = (MW > 1) ? $clog2(MW) : 1;
	localparam int PXW   = MAW + 5;
	localparam int END_W = (SLOTS - 1) / 32;
	localparam int END_B = (SLOTS - 1) % 32;

	// the fixed end marks are never stored, they are or'ed into every word read
	function automatic logic [31:0] sentinel(input logic [MAW-1:0] w);
		logic [31:0] s;
		s = '0;
		if (32'(w) == 0)
			s[0] = 1'b1;
		if (32'(w) == END_W)
			s[END_B] = 1'b1;
		return s;
	endfunction

	function automatic logic [4:0] hi_bit(input logic [31:0] v);
		logic [4:0] r;
		r = '0;
		for (int i = 0; i < 32; i++)
			if (v[i])
				r = 5'(i);
		return r;
	endfunction

	function automatic logic [4:0] lo_bit(input logic [31:0] v);
		logic [4:0] r;
		r = '0;
		for (int i = 31; i >= 0; i--)
			if (v[i])
				r = 5'(i);
		return r;
	endfunction

	// memories
	logic [31:0]    map_mem [MW];
	logic [GW-1:0]  tree_mem [TSZ];
	logic           map_we, tree_we;
	logic [MAW-1:0] map_waddr, map_raddr;
	logic [31:0]    map_wdata, map_rd;
	logic [TW-1:0]  tree_waddr, tree_raddr;
	logic [GW-1:0]  tree_wdata, tree_rd;

	// control registers
	state_t         state_q, state_d;
	logic [TW-1:0]  cnt_q, cnt_d;
	logic           done_q, done_d;
	logic           pend_q, pend_d;

	// payload registers
	logic [POS_W-1:0] x_q, x_d, sz_q, sz_d, span_q, span_d;
	logic             cmd_q, cmd_d, ph_q, ph_d, fits_q, fits_d;
	logic [MAW-1:0]   w_q, w_d;
	logic [31:0]      msk_q, msk_d;
	logic [PXW-1:0]   prev_q, prev_d, next_q, next_d;
	logic [TW-1:0]    l_q, l_d, r_q, r_d, cur_q, cur_d;
	logic [GW-1:0]    val_q, val_d, best_q, best_d;

	always_ff @(posedge clk) begin
		if (map_we)
			map_mem[map_waddr] <= map_wdata;
		map_rd <= map_mem[map_raddr];
	end

	always_ff @(posedge clk) begin
		if (tree_we)
			tree_mem[tree_waddr] <= tree_wdata;
		tree_rd <= tree_mem[tree_raddr];
	end

	always_comb begin
		logic [31:0] t32, x32, word, hit, rr;
		logic [PXW-1:0] p;
		x32 = {{(32 - POS_W){1'b0}}, x_q};
		t32 = '0;
		word = '0;
		hit = '0;
		rr = '0;
		p = '0;

		state_d = state_q;
		cnt_d = cnt_q;
		done_d = 1'b0;
		pend_d = 1'b0;
		x_d = x_q;
		sz_d = sz_q;
		cmd_d = cmd_q;
		span_d = span_q;
		ph_d = ph_q;
		fits_d = fits_q;
		w_d = w_q;
		msk_d = msk_q;
		prev_d = prev_q;
		next_d = next_q;
		l_d = l_q;
		r_d = r_q;
		cur_d = cur_q;
		val_d = val_q;
		// a tree read issued last cycle folds into the running max
		best_d = (pend_q && tree_rd > best_q) ? tree_rd : best_q;

		map_we = 1'b0;
		map_waddr = w_q;
		map_wdata = '0;
		map_raddr = w_q;
		tree_we = 1'b0;
		tree_waddr = cur_q;
		tree_wdata = val_q;
		tree_raddr = cur_q ^ TW'(1);

		unique case (state_q)
			ST_CLR: begin
				tree_we = 1'b1;
				tree_waddr = cnt_q;
				tree_wdata = '0;
				if (32'(cnt_q) < MW) begin
					map_we = 1'b1;
					map_waddr = cnt_q[MAW-1:0];
				end
				cnt_d = cnt_q + TW'(1);
				if (32'(cnt_q) == TSZ - 1)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					x_d = position;
					sz_d = block_size;
					cmd_d = command;
					t32 = {{(32 - POS_W){1'b0}}, position};
					if (command == CMD_INSERT) begin
						// out of range inserts are dropped here
						if (position != '0 && t32 <= 32'(MAX_POS)) begin
							w_d = t32[PXW-1:5];
							map_raddr = t32[PXW-1:5];
							state_d = ST_ICHK;
						end
					end else if (position == '0) begin
						done_d = 1'b1;
						fits_d = (block_size == '0);
					end else begin
						t32 = t32 - 32'd1;
						if (t32 > 32'(MAX_POS))
							t32 = 32'(MAX_POS);
						w_d = t32[PXW-1:5];
						map_raddr = t32[PXW-1:5];
						msk_d = 32'hFFFF_FFFF >> (5'd31 - t32[4:0]);
						state_d = ST_BELOW;
					end
				end
			end
			ST_ICHK: begin
				word = map_rd | sentinel(w_q);
				if (word[x_q[4:0]]) begin
					// already occupied
					state_d = ST_IDLE;
				end else begin
					map_we = 1'b1;
					map_wdata = map_rd | (32'd1 << x_q[4:0]);
					t32 = x32 - 32'd1;
					w_d = t32[PXW-1:5];
					map_raddr = t32[PXW-1:5];
					msk_d = 32'hFFFF_FFFF >> (5'd31 - t32[4:0]);
					state_d = ST_BELOW;
				end
			end
			ST_BELOW: begin
				word = map_rd | sentinel(w_q);
				hit = word & msk_q;
				if (hit != '0) begin
					p = {w_q, hi_bit(hit)};
					prev_d = p;
					if (cmd_q == CMD_INSERT) begin
						t32 = x32 + 32'd1;
						w_d = t32[PXW-1:5];
						map_raddr = t32[PXW-1:5];
						msk_d = 32'hFFFF_FFFF << t32[4:0];
						state_d = ST_ABOVE;
					end else begin
						t32 = x32 - 32'(p);
						span_d = t32[POS_W-1:0];
						l_d = TW'(SLOTS);
						t32 = 32'(p) + 32'(SLOTS) + 32'd1;
						r_d = t32[TW-1:0];
						best_d = '0;
						state_d = ST_QA;
					end
				end else begin
					// position 0 is always set, so this stops at word 0
					w_d = w_q - MAW'(1);
					map_raddr = w_q - MAW'(1);
					msk_d = 32'hFFFF_FFFF;
				end
			end
			ST_ABOVE: begin
				word = map_rd | sentinel(w_q);
				hit = word & msk_q;
				if (hit != '0) begin
					next_d = {w_q, lo_bit(hit)};
					t32 = x32 + 32'(SLOTS);
					cur_d = t32[TW-1:0];
					t32 = x32 - 32'(prev_q);
					val_d = t32[GW-1:0];
					ph_d = 1'b0;
					state_d = ST_TWR;
				end else begin
					w_d = w_q + MAW'(1);
					map_raddr = w_q + MAW'(1);
					msk_d = 32'hFFFF_FFFF;
				end
			end
			ST_TWR: begin
				// write the node, then fetch its sibling for the parent
				tree_we = 1'b1;
				if (cur_q == TW'(1)) begin
					if (!ph_q) begin
						ph_d = 1'b1;
						t32 = 32'(next_q) + 32'(SLOTS);
						cur_d = t32[TW-1:0];
						t32 = 32'(next_q) - x32;
						val_d = t32[GW-1:0];
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_TMX;
				end
			end
			ST_TMX: begin
				val_d = (tree_rd > val_q) ? tree_rd : val_q;
				cur_d = cur_q >> 1;
				state_d = ST_TWR;
			end
			ST_QA: begin
				if (l_q < r_q) begin
					if (l_q[0]) begin
						tree_raddr = l_q;
						pend_d = 1'b1;
						l_d = l_q + TW'(1);
					end
					state_d = ST_QB;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_QB: begin
				rr = 32'(r_q);
				if (r_q[0]) begin
					rr = rr - 32'd1;
					tree_raddr = rr[TW-1:0];
					pend_d = 1'b1;
				end
				l_d = l_q >> 1;
				r_d = rr[TW:1];
				state_d = ST_QA;
			end
			ST_OUT: begin
				done_d = 1'b1;
				fits_d = (span_q >= sz_q) || (32'(best_q) >= 32'(sz_q));
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			cnt_q <= '0;
			done_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			done_q <= done_d;
			pend_q <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		x_q <= x_d;
		sz_q <= sz_d;
		cmd_q <= cmd_d;
		span_q <= span_d;
		ph_q <= ph_d;
		fits_q <= fits_d;
		w_q <= w_d;
		msk_q <= msk_d;
		prev_q <= prev_d;
		next_q <= next_d;
		l_q <= l_d;
		r_q <= r_d;
		cur_q <= cur_d;
		val_q <= val_d;
		best_q <= best_d;
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign fits = fits_q;

`include "obstacle_gap_fit_tracker_core_assert.svh"
	`OGFT_ASSERT_IMPL(a_state_onehot, 1'b1, $onehot(state_q))
	`OGFT_ASSERT_NEXT(a_insert_silent, start && !busy && command == CMD_INSERT, !done)
	`OGFT_ASSERT_IMPL(a_tree_cursor, state_q == ST_TWR || state_q == ST_TMX, cur_q != '0)
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

// fit tracker testbench: a predictor keeps its own obstacle map and gap list,
// a scoreboard class holds the expected fit answers in order of acceptance
module tb_top;
	import ogft_pkg::*;

	localparam int MAX_POS   = 1024;
	localparam int SLOTS     = MAX_POS + 2;
	localparam int STALL_MAX = 20000;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             command;
	logic [POS_W-1:0] position;
	logic [POS_W-1:0] block_size;
	logic             done;
	logic             fits;

	// predictor state: occupied positions and the gap back to the previous one
	bit           occupied [SLOTS];
	int unsigned  gap_back [SLOTS];
	int           n_ins;
	int           n_fit;
	int           n_fits_true;
	int           idle_cycles;
	bit           timed_out;

	class fit_scoreboard;
		bit expected_fits[$];
		int errors;

		// append one expected answer at the tail
		function void queue_answer(bit v);
			expected_fits = {expected_fits, v};
		endfunction

		// note an accepted transaction; only a fit query leaves an answer behind
		function void note_transaction(logic cmd, int unsigned x, int unsigned sz);
			int unsigned prev;
			int unsigned nxt;
			int unsigned span;
			int unsigned lim;
			if (cmd == CMD_INSERT) begin
				if (x == 0 || x > MAX_POS || occupied[x])
					return;
				prev = x - 1;
				while (prev > 0 && !occupied[prev])
					prev--;
				nxt = x + 1;
				while (nxt < MAX_POS + 1 && !occupied[nxt])
					nxt++;
				occupied[x] = 1'b1;
				gap_back[x] = x - prev;
				gap_back[nxt] = nxt - x;
				return;
			end
			if (x == 0) begin
				queue_answer(sz == 0);
				return;
			end
			lim = (x - 1 > MAX_POS) ? MAX_POS : x - 1;
			prev = lim;
			while (prev > 0 && !occupied[prev])
				prev--;
			span = x - prev;
			for (int i = 0; i <= prev; i++)
				if (gap_back[i] > span)
					span = gap_back[i];
			queue_answer(span >= sz);
		endfunction

		function void check_fits(logic actual);
			if (expected_fits.size() == 0) begin
				$error("fits result with no query outstanding: actual %0b", actual);
				errors++;
				return;
			end
			if (expected_fits[0] !== actual) begin
				$error("fits mismatch: expected %0b actual %0b", expected_fits[0], actual);
				errors++;
			end
			if (actual === 1'b1)
				n_fits_true++;
			void'(expected_fits.pop_front());
		endfunction
	endclass

	fit_scoreboard sb;

	obstacle_gap_fit_tracker_core #(.MAX_POS(MAX_POS)) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.position   (position),
		.block_size (block_size),
		.done       (done),
		.fits       (fits)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// results cannot be held off, so every done strobe is checked at its edge
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_fits(fits);
	end

	// watchdog: counts edges at which no transaction moves on either side
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_MAX && !timed_out) begin
			timed_out = 1'b1;
			$display("** obstacle_gap_fit_tracker_core: FAILED **");
			$finish;
		end
	end

	// random gap before a transaction: mostly none or short, now and then long
	task automatic idle_gap();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 50)
			n = 0;
		else if (r < 92)
			n = $urandom_range(1, 4);
		else
			n = $urandom_range(10, 80);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// present one transaction and hold it until the block takes it
	task automatic send_cmd(logic cmd, int unsigned x, int unsigned sz);
		idle_gap();
		start      <= 1'b1;
		command    <= cmd;
		position   <= x[POS_W-1:0];
		block_size <= sz[POS_W-1:0];
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_transaction(cmd, x, sz);
		if (cmd == CMD_INSERT)
			n_ins++;
		else
			n_fit++;
	endtask

	task automatic send_random_fit();
		int unsigned x;
		int unsigned sz;
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			x = $urandom_range(MAX_POS + 1, 2047);
		else if (r < 8)
			x = 0;
		else
			x = $urandom_range(1, MAX_POS);
		r = $urandom_range(0, 99);
		if (r < 60)
			sz = $urandom_range(1, 64);
		else if (r < 70)
			sz = 0;
		else
			sz = $urandom_range(0, 2047);
		send_cmd(CMD_FIT, x, sz);
	endtask

	initial begin
		int unsigned x;
		int waited;
		sb          = new();
		timed_out   = 1'b0;
		idle_cycles = 0;
		n_ins       = 0;
		n_fit       = 0;
		n_fits_true = 0;
		for (int i = 0; i < SLOTS; i++) begin
			occupied[i] = 1'b0;
			gap_back[i] = 0;
		end
		occupied[0]       = 1'b1;
		occupied[SLOTS-1] = 1'b1;
		arst_n     = 1'b0;
		start      = 1'b0;
		command    = CMD_INSERT;
		position   = '0;
		block_size = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty line, extremes, zero sizes, out-of-range inserts, repeats
		send_cmd(CMD_FIT, MAX_POS, MAX_POS);
		send_cmd(CMD_FIT, MAX_POS, MAX_POS + 1);
		send_cmd(CMD_FIT, 0, 0);
		send_cmd(CMD_FIT, 0, 1);
		send_cmd(CMD_FIT, 2047, 2047);
		send_cmd(CMD_FIT, 1, 0);
		send_cmd(CMD_INSERT, 0, 5);
		send_cmd(CMD_INSERT, MAX_POS + 1, 0);
		send_cmd(CMD_INSERT, 2047, 2047);
		send_cmd(CMD_INSERT, 512, 0);
		send_cmd(CMD_INSERT, 512, 3);
		send_cmd(CMD_INSERT, 1, 0);
		send_cmd(CMD_INSERT, MAX_POS, 0);
		send_cmd(CMD_FIT, 512, 511);
		send_cmd(CMD_FIT, 512, 512);
		send_cmd(CMD_FIT, MAX_POS, 511);
		send_cmd(CMD_FIT, 2047, 1047);
		send_cmd(CMD_FIT, 2047, 1048);
		send_cmd(CMD_FIT, 1, 1);
		send_cmd(CMD_FIT, 2, 1);
		send_cmd(CMD_FIT, 1365, 682);

		// random: sparse inserts keep large gaps alive, fits probe everywhere
		for (int i = 0; i < 1130; i++) begin
			if ($urandom_range(0, 99) < 35) begin
				if ($urandom_range(0, 9) == 0)
					x = $urandom_range(0, 2047);
				else
					x = $urandom_range(1, MAX_POS);
				send_cmd(CMD_INSERT, x, $urandom_range(0, 2047));
			end else begin
				send_random_fit();
			end
		end
		start <= 1'b0;

		waited = 0;
		while (sb.expected_fits.size() != 0 && waited < STALL_MAX) begin
			@(posedge clk);
			waited++;
		end
		repeat (200) @(posedge clk);

		$display("covered %0d inserts and %0d fit queries, %0d answered fits",
			n_ins, n_fit, n_fits_true);
		if (sb.errors == 0 && sb.expected_fits.size() == 0)
			$display("** obstacle_gap_fit_tracker_core: PASSED **");
		else
			$display("** obstacle_gap_fit_tracker_core: FAILED **");
		$finish;
	end
endmodule
